// ===== rtl/scd_pkg.sv =====
// Shared constants, types and helpers for the serial command packet deframer.
package scd_pkg;

	localparam int BufferSize = 20;
	localparam int PosW = $clog2(BufferSize + 1);

	localparam logic [7:0] HeaderFirst = 8'h66;
	localparam logic [7:0] HeaderSecond = 8'hCC;
	localparam logic [7:0] LengthExtra = 8'd3;
	localparam logic [16:0] ValueOffset = 17'd32767;

	// Buffer positions that hold the two little-endian value words.
	localparam logic [PosW-1:0] ValueFirstPos = PosW'(4);
	localparam logic [PosW-1:0] ValueLastPos = PosW'(7);
	localparam logic [PosW-1:0] LengthPos = PosW'(3);
	localparam logic [PosW-1:0] HeaderEndPos = PosW'(2);
	localparam logic [PosW-1:0] BufferEnd = PosW'(BufferSize);

	localparam int InDataW = 8;
	localparam int OutFieldsW = 1 + 17 + 17;
	localparam int OutDataW = ((OutFieldsW + 7) / 8) * 8;

	typedef struct packed {
		logic               hit;
		logic               checksum_ok;
		logic signed [16:0] speed_hundredths;
		logic signed [16:0] steer_hundredths;
	} scd_result_t;

	// 16-bit word minus the mid-scale offset, kept as a 17-bit signed value.
	function automatic logic signed [16:0] word_minus_offset(input logic [7:0] lo,
			input logic [7:0] hi);
		logic [16:0] word;
		word = {1'b0, hi, lo};
		return $signed(word - ValueOffset);
	endfunction

endpackage

// ===== rtl/scd_frame.sv =====
// Packet framing state and per-byte decode: header hunt, length, checksum and values.
module scd_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output scd_pkg::scd_result_t result
);

	logic [scd_pkg::PosW-1:0] pos_q;
	logic                     in_packet_q;
	logic [7:0]               exp_len_q;
	logic [7:0]               prev_byte_q;
	logic [7:0]               sum_q;
	logic [7:0]               value_q [4];

	logic [7:0]               value_cur [4];
	logic [scd_pkg::PosW-1:0] pos_inc;
	logic [scd_pkg::PosW-1:0] pos_next;
	logic                     in_packet_next;
	logic [7:0]               exp_len_next;
	logic [7:0]               sum_next;
	logic                     is_header;
	logic                     is_length;
	logic                     is_last;
	logic                     ok;

	// The incoming byte is stored first, so a packet ending inside the value
	// field reports the byte just received.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			value_cur[i] = value_q[i];
		end
		if (pos_q >= scd_pkg::ValueFirstPos && pos_q <= scd_pkg::ValueLastPos) begin
			value_cur[2'(pos_q - scd_pkg::ValueFirstPos)] = rx_byte;
		end
	end

	assign pos_inc = pos_q + scd_pkg::PosW'(1);
	assign is_header = !in_packet_q && (pos_inc > scd_pkg::PosW'(1))
		&& (rx_byte == scd_pkg::HeaderSecond) && (prev_byte_q == scd_pkg::HeaderFirst);
	assign is_length = in_packet_q && (pos_inc == scd_pkg::LengthPos);
	assign is_last = in_packet_q && (8'(pos_inc) == exp_len_q);
	assign ok = (rx_byte == sum_q);

	always_comb begin
		pos_next = pos_inc;
		in_packet_next = in_packet_q;
		exp_len_next = exp_len_q;
		sum_next = sum_q;
		if (is_header) begin
			in_packet_next = 1'b1;
			pos_next = scd_pkg::HeaderEndPos;
		end else if (is_length) begin
			exp_len_next = rx_byte + scd_pkg::LengthExtra;
			sum_next = rx_byte;
		end else if (is_last) begin
			in_packet_next = 1'b0;
			if (pos_inc >= scd_pkg::BufferEnd) begin
				pos_next = '0;
			end
		end else begin
			if (in_packet_q) begin
				sum_next = sum_q + rx_byte;
			end
			if (pos_inc >= scd_pkg::BufferEnd) begin
				pos_next = '0;
				in_packet_next = 1'b0;
			end
		end
	end

	always_comb begin
		result.hit = !is_header && !is_length && is_last;
		result.checksum_ok = ok;
		result.speed_hundredths = ok ? scd_pkg::word_minus_offset(value_cur[0], value_cur[1])
			: '0;
		result.steer_hundredths = ok ? scd_pkg::word_minus_offset(value_cur[2], value_cur[3])
			: '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			in_packet_q <= 1'b0;
			exp_len_q <= '0;
			prev_byte_q <= '0;
			sum_q <= '0;
			for (int i = 0; i < 4; i++) begin
				value_q[i] <= '0;
			end
		end else if (step) begin
			pos_q <= pos_next;
			in_packet_q <= in_packet_next;
			exp_len_q <= exp_len_next;
			prev_byte_q <= rx_byte;
			sum_q <= sum_next;
			for (int i = 0; i < 4; i++) begin
				value_q[i] <= value_cur[i];
			end
		end
	end

endmodule

// ===== rtl/serial_command_packet_deframer_core.sv =====
// Top level of the serial command packet deframer: stream ports and pipeline registers.
//
// Usage: feed received serial bytes, one per transaction, on the slave stream
// (s_tvalid, s_tready, s_tdata). The block hunts for the header 0x66 0xCC,
// reads the length byte, keeps a running checksum and, when the last packet
// byte arrives, emits one result transaction on the master stream carrying
// the checksum status and the speed and steering values in hundredths.
// Bytes that do not end a packet produce no result transaction.
// Path: a byte is captured in an input register, decoded combinationally and
// its result is written to the output register when the decode stage advances,
// so a result is offered from the output register after the last byte is accepted.
// Throughput: one byte per cycle while no pending result is stalled, limited by the single decode stage
// between the input and output registers.
// Stall: when the receiver holds m_tready low, the pending result stays in
// the output register and the decode stage stops, so at most one more byte
// is taken into the input register before s_tready drops.
// Reset: arst_n clears the framing state, the position counter, the sum,
// the stored value bytes and both valid flags; no transaction is pending.
module serial_command_packet_deframer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [scd_pkg::InDataW-1:0]       s_tdata,  // [7:0] rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] checksum_ok, [17:1] speed_hundredths, [34:18] steer_hundredths, rest zero
	output logic [scd_pkg::OutDataW-1:0]      m_tdata
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  out_valid_q;
	logic [scd_pkg::OutFieldsW-1:0] out_data_q;
	logic                  advance;
	scd_pkg::scd_result_t  result;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
		end
	end

	scd_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.hit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.hit) begin
			out_data_q <= {result.steer_hundredths, result.speed_hundredths,
				result.checksum_ok};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(scd_pkg::OutDataW - scd_pkg::OutFieldsW){1'b0}}, out_data_q};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the serial command packet deframer core.
`timescale 1ns / 100ps

module testbench;

	localparam int ItemTarget = 1100;
	localparam int CycleLimit = 400000;

	typedef struct packed {
		logic        checksum_ok;
		logic [16:0] speed;
		logic [16:0] steer;
	} command_t;

	// Tracks the framing state alongside the block and queues the commands it must emit.
	class packet_scoreboard;
		logic [scd_pkg::PosW-1:0] position;
		logic            in_packet;
		logic [7:0]      frame_len;
		logic [7:0]      last_rx;
		logic [7:0]      checksum;
		logic [7:0]      value_bytes [4];
		command_t        pending_commands [$];
		int unsigned     mismatches;
		int unsigned     results_seen;

		function new();
			position = '0;
			in_packet = 1'b0;
			frame_len = '0;
			last_rx = '0;
			checksum = '0;
			foreach (value_bytes[i]) value_bytes[i] = '0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return pending_commands.size();
		endfunction

		// Little-endian word shifted down by mid-scale, wrapped to 17 bits.
		function logic [16:0] centered_word(logic [7:0] lo, logic [7:0] hi);
			logic [16:0] raw;
			raw = {1'b0, hi, lo};
			return raw - 17'd32767;
		endfunction

		function void note_byte(logic [7:0] rx);
			logic [scd_pkg::PosW-1:0] slot;
			logic [scd_pkg::PosW-1:0] next_pos;
			command_t cmd;
			slot = position;
			if (slot >= scd_pkg::ValueFirstPos && slot <= scd_pkg::ValueLastPos) begin
				value_bytes[2'(slot - scd_pkg::ValueFirstPos)] = rx;
			end
			next_pos = slot + 1'b1;
			if (!in_packet && next_pos > 1 && rx == scd_pkg::HeaderSecond
					&& last_rx == scd_pkg::HeaderFirst) begin
				in_packet = 1'b1;
				next_pos = scd_pkg::HeaderEndPos;
			end else if (in_packet && next_pos == scd_pkg::LengthPos) begin
				frame_len = rx + scd_pkg::LengthExtra;
				checksum = rx;
			end else if (in_packet && int'(next_pos) == int'(frame_len)) begin
				cmd.checksum_ok = (rx == checksum);
				cmd.speed = cmd.checksum_ok ? centered_word(value_bytes[0], value_bytes[1]) : '0;
				cmd.steer = cmd.checksum_ok ? centered_word(value_bytes[2], value_bytes[3]) : '0;
				pending_commands.push_back(cmd);
				in_packet = 1'b0;
				if (int'(next_pos) >= scd_pkg::BufferSize) next_pos = '0;
			end else begin
				if (in_packet) checksum = checksum + rx;
				if (int'(next_pos) >= scd_pkg::BufferSize) begin
					next_pos = '0;
					in_packet = 1'b0;
				end
			end
			last_rx = rx;
			position = next_pos;
		endfunction

		task report(string what);
			$display("mismatch at result %0d: %s", results_seen, what);
			mismatches++;
		endtask

		task check_result(logic [scd_pkg::OutDataW-1:0] data);
			command_t want;
			results_seen++;
			if (pending_commands.size() == 0) begin
				report($sformatf("no command expected, got data %h", data));
				return;
			end
			want = pending_commands.pop_front();
			if (data[0] !== want.checksum_ok)
				report($sformatf("checksum_ok %b, want %b", data[0], want.checksum_ok));
			if (data[17:1] !== want.speed)
				report($sformatf("speed %0d, want %0d", $signed(data[17:1]), $signed(want.speed)));
			if (data[34:18] !== want.steer)
				report($sformatf("steer %0d, want %0d", $signed(data[34:18]), $signed(want.steer)));
			if (data[scd_pkg::OutDataW-1:35] !== '0)
				report($sformatf("padding bits %h not zero", data[scd_pkg::OutDataW-1:35]));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [scd_pkg::InDataW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [scd_pkg::OutDataW-1:0] m_tdata;

	packet_scoreboard sb = new();
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;
	int unsigned stall_tick = 0;

	serial_command_packet_deframer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: check each accepted transaction, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 150);
		end
		mode_left--;
		stall_tick++;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (stall_tick % 4 == 0);
			default: m_tready <= (stall_tick % 12 >= 8);
		endcase
	end

	task automatic send_byte(input logic [7:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(value);
		items_sent++;
	endtask

	function automatic logic [15:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 2) return 16'h0000;
		if (r < 4) return 16'hFFFF;
		if (r == 4) return 16'h7FFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// Builds a framed packet; header_pct biases payload toward header byte pairs.
	task automatic send_packet(input logic [7:0] len_byte, input logic [15:0] speed_word,
			input logic [15:0] steer_word, input bit corrupt, input int unsigned keep,
			input int unsigned header_pct);
		logic [7:0] frame [$];
		logic [7:0] total;
		logic [7:0] sum;
		logic [7:0] value;
		int unsigned body;
		int unsigned count;
		total = len_byte + scd_pkg::LengthExtra;
		if (total >= 4 && total <= scd_pkg::BufferSize) body = total;
		else body = 3 + $urandom_range(0, 22);
		frame.push_back(scd_pkg::HeaderFirst);
		frame.push_back(scd_pkg::HeaderSecond);
		frame.push_back(len_byte);
		for (int i = 3; i < body; i++) begin
			case (i)
				4: value = speed_word[7:0];
				5: value = speed_word[15:8];
				6: value = steer_word[7:0];
				7: value = steer_word[15:8];
				default: begin
					if ($urandom_range(0, 99) < header_pct)
						value = (i % 2 == 0) ? scd_pkg::HeaderFirst : scd_pkg::HeaderSecond;
					else
						value = 8'($urandom_range(0, 255));
				end
			endcase
			frame.push_back(value);
		end
		if (body == total) begin
			sum = '0;
			for (int i = 2; i < body - 1; i++) sum = sum + frame[i];
			if (corrupt) sum = sum + 8'($urandom_range(1, 255));
			frame[body - 1] = sum;
		end
		count = (keep != 0 && keep < frame.size()) ? keep : frame.size();
		for (int i = 0; i < count; i++) send_byte(frame[i]);
	endtask

	task automatic send_noise(input int unsigned count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: send_byte(scd_pkg::HeaderFirst);
				1: send_byte(scd_pkg::HeaderSecond);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic run_directed();
		send_packet(8'd5, 16'h0000, 16'hFFFF, 1'b0, 0, 0);
		send_packet(8'd5, 16'hFFFF, 16'h0000, 1'b0, 0, 0);
		send_packet(8'd5, 16'h7FFF, 16'h8000, 1'b1, 0, 0);
		// Packets that end before or inside the value bytes reuse whatever was stored last for the rest.
		send_packet(8'd1, 16'h1234, 16'h5678, 1'b0, 0, 0);
		send_packet(8'd3, 16'hABCD, 16'h0001, 1'b0, 0, 0);
		// A packet filling the buffer exactly must rewind the position for the next one.
		send_packet(8'(scd_pkg::BufferSize - 3), 16'h8001, 16'h7FFE, 1'b0, 0, 0);
		send_packet(8'd9, 16'h00FF, 16'hFF00, 1'b0, 0, 0);
		// Lengths that can never complete, each followed by enough filler to drop them.
		send_packet(8'(scd_pkg::BufferSize - 2), 16'h0000, 16'h0000, 1'b0, 0, 0);
		repeat (scd_pkg::BufferSize) send_byte(8'h00);
		send_packet(8'd0, 16'h0000, 16'h0000, 1'b0, 0, 0);
		repeat (scd_pkg::BufferSize) send_byte(8'h00);
		send_packet(8'd255, 16'h0000, 16'h0000, 1'b0, 0, 0);
		repeat (scd_pkg::BufferSize) send_byte(8'h00);
		send_packet(8'd253, 16'h0000, 16'h0000, 1'b0, 0, 0);
		repeat (scd_pkg::BufferSize) send_byte(8'hFF);
		// Header byte pairs inside a packet are plain payload.
		send_packet(8'd12, 16'h4321, 16'hC0DE, 1'b0, 0, 100);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_packet(8'd6, 16'h0000, 16'hFFFF, 1'b0, 0, 0);
	endtask

	initial begin
		int unsigned pick;
		logic [7:0] len_byte;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (items_sent < ItemTarget) begin
			pick = $urandom_range(0, 99);
			len_byte = 8'($urandom_range(1, scd_pkg::BufferSize - 3));
			if (pick < 70)
				send_packet(len_byte, pick_word(), pick_word(), $urandom_range(0, 6) == 0, 0, 5);
			else if (pick < 78)
				send_packet(8'($urandom_range(0, 255)), pick_word(), pick_word(), 1'b0, 0, 5);
			else if (pick < 88)
				send_packet(len_byte, pick_word(), pick_word(), 1'b0,
					$urandom_range(1, int'(len_byte) + 2), 5);
			else
				send_noise($urandom_range(1, 8));
		end
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== serial_command_packet_deframer_core.f =====
rtl/scd_pkg.sv
rtl/scd_frame.sv
rtl/serial_command_packet_deframer_core.sv
tb/testbench.sv
